// ----- hdl/rhr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_pkg
// Types and constants shared by the hue rotation pipeline and its checker.
// ----------------------------------------------------------------------------
package rhr_pkg;

    localparam int CHANNEL_BITS_DEF = 8;
    localparam int HUE_BITS_DEF     = 16;
    localparam int SHIFT_BITS       = 16;
    localparam int PORT_CH_BITS     = 8;

    typedef struct packed {
        logic [PORT_CH_BITS-1:0] red_in;
        logic [PORT_CH_BITS-1:0] green_in;
        logic [PORT_CH_BITS-1:0] blue_in;
        logic [SHIFT_BITS-1:0]   hue_shift;
    } pixel_in_t;

    typedef struct packed {
        logic [PORT_CH_BITS-1:0] red_out;
        logic [PORT_CH_BITS-1:0] green_out;
        logic [PORT_CH_BITS-1:0] blue_out;
    } pixel_out_t;

    typedef enum logic [2:0] {
        SECTOR_RED_UP   = 3'd0,
        SECTOR_GRN_DOWN = 3'd1,
        SECTOR_GRN_UP   = 3'd2,
        SECTOR_BLU_DOWN = 3'd3,
        SECTOR_BLU_UP   = 3'd4,
        SECTOR_RED_DOWN = 3'd5
    } sector_t;

endpackage

// ----- hdl/rgb_hue_rotation_unit.sv -----
`timescale 1ns / 1ps
// registers in order: stage 1, divider input, divider, hue, products, output
// throughput: one item per cycle unless the result side stalls; the hue divider
// is one restoring stage per quotient bit, so its HUE_BITS + 1 stages set the
// depth, not the rate; a stall on the result side freezes the whole pipeline
// reset: asynchronous, active low, clears all stage valid bits
// ----------------------------------------------------------------------------
// rgb_hue_rotation_unit
// Rotates the hue of an rgb pixel via hsv, pipelined divider and multipliers.
// ----------------------------------------------------------------------------
module rgb_hue_rotation_unit
    import rhr_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int HUE_BITS     = HUE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_ready,
    input  pixel_in_t  pixel,
    output logic       result_valid,
    input  logic       result_ready,
    output pixel_out_t result
);

    localparam int CB   = CHANNEL_BITS;
    localparam int HB   = HUE_BITS;
    localparam int QW   = HB + 1;
    localparam int DW   = CB + 4;
    localparam int NW   = QW + DW;
    localparam int PW   = CB + HB + 2;

    logic en;

    // ---------------- stage 1: max, min, delta, hue numerator
    logic [CB-1:0] r_next, g_next, b_next, mx_next, mn_next, d_next;
    logic [DW-1:0] num_next;
    logic [HB-1:0] shift_next;

    always_comb
    begin
        r_next = CB'(pixel.red_in);
        g_next = CB'(pixel.green_in);
        b_next = CB'(pixel.blue_in);
        mx_next = r_next;
        if (g_next > mx_next) mx_next = g_next;
        if (b_next > mx_next) mx_next = b_next;
        mn_next = r_next;
        if (g_next < mn_next) mn_next = g_next;
        if (b_next < mn_next) mn_next = b_next;
        d_next = mx_next - mn_next;
        // one full turn added so the numerator never goes negative
        priority if (mx_next == r_next)
            num_next = (DW'(d_next) << 2) + (DW'(d_next) << 1) + DW'(g_next) - DW'(b_next);
        else if (mx_next == g_next)
            num_next = (DW'(d_next) << 3) + DW'(b_next) - DW'(r_next);
        else
            num_next = (DW'(d_next) << 3) + (DW'(d_next) << 1) + DW'(r_next) - DW'(g_next);
    end

    generate
        if (HB >= SHIFT_BITS)
        begin : g_shift_up
            assign shift_next = HB'(pixel.hue_shift) << (HB - SHIFT_BITS);
        end
        else
        begin : g_shift_down
            logic [SHIFT_BITS:0] shift_sum;
            assign shift_sum = {1'b0, pixel.hue_shift}
                             + ((SHIFT_BITS+1)'(1) << (SHIFT_BITS - HB - 1));
            assign shift_next = HB'(shift_sum >> (SHIFT_BITS - HB));
        end
    endgenerate

    logic          s1_vld_reg;
    logic [CB-1:0] s1_r_reg, s1_g_reg, s1_b_reg, s1_mx_reg, s1_mn_reg, s1_d_reg;
    logic [DW-1:0] s1_num_reg;
    logic [HB-1:0] s1_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg     <= r_next;
            s1_g_reg     <= g_next;
            s1_b_reg     <= b_next;
            s1_mx_reg    <= mx_next;
            s1_mn_reg    <= mn_next;
            s1_d_reg     <= d_next;
            s1_num_reg   <= num_next;
            s1_shift_reg <= shift_next;
        end
    end

    // ---------------- divider: one quotient bit per stage
    logic          dv_vld_reg   [0:QW];
    logic [CB-1:0] dv_r_reg     [0:QW];
    logic [CB-1:0] dv_g_reg     [0:QW];
    logic [CB-1:0] dv_b_reg     [0:QW];
    logic [CB-1:0] dv_mx_reg    [0:QW];
    logic [CB-1:0] dv_mn_reg    [0:QW];
    logic [CB-1:0] dv_d_reg     [0:QW];
    logic [HB-1:0] dv_shift_reg [0:QW];
    logic [DW-1:0] dv_rem_reg   [0:QW];
    logic [QW-1:0] dv_low_reg   [0:QW];
    logic [QW-1:0] dv_quo_reg   [0:QW];

    // dividend 2*num*2^HB + 6d over divisor 12d gives the rounded hue
    logic [NW-1:0] dividend_next;
    assign dividend_next = (NW'(s1_num_reg) << (HB + 1))
                         + (NW'(s1_d_reg) << 2) + (NW'(s1_d_reg) << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (en)
            dv_vld_reg[0] <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_r_reg[0]     <= s1_r_reg;
            dv_g_reg[0]     <= s1_g_reg;
            dv_b_reg[0]     <= s1_b_reg;
            dv_mx_reg[0]    <= s1_mx_reg;
            dv_mn_reg[0]    <= s1_mn_reg;
            dv_d_reg[0]     <= s1_d_reg;
            dv_shift_reg[0] <= s1_shift_reg;
            dv_rem_reg[0]   <= dividend_next[NW-1:QW];
            dv_low_reg[0]   <= dividend_next[QW-1:0];
            dv_quo_reg[0]   <= '0;
        end
    end

    generate
        for (genvar k = 0; k < QW; k++)
        begin : g_div
            logic [DW:0]   trial_next;
            logic [DW:0]   dvs_next;
            logic          qbit_next;
            logic [DW-1:0] rem_next;

            always_comb
            begin
                trial_next = {dv_rem_reg[k], dv_low_reg[k][QW-1]};
                dvs_next   = ((DW+1)'(dv_d_reg[k]) << 3) + ((DW+1)'(dv_d_reg[k]) << 2);
                qbit_next  = (trial_next >= dvs_next);
                rem_next   = qbit_next ? DW'(trial_next - dvs_next) : DW'(trial_next);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_vld_reg[k+1] <= 1'b0;
                else if (en)
                    dv_vld_reg[k+1] <= dv_vld_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_r_reg[k+1]     <= dv_r_reg[k];
                    dv_g_reg[k+1]     <= dv_g_reg[k];
                    dv_b_reg[k+1]     <= dv_b_reg[k];
                    dv_mx_reg[k+1]    <= dv_mx_reg[k];
                    dv_mn_reg[k+1]    <= dv_mn_reg[k];
                    dv_d_reg[k+1]     <= dv_d_reg[k];
                    dv_shift_reg[k+1] <= dv_shift_reg[k];
                    dv_rem_reg[k+1]   <= rem_next;
                    dv_low_reg[k+1]   <= dv_low_reg[k] << 1;
                    dv_quo_reg[k+1]   <= {dv_quo_reg[k][QW-2:0], qbit_next};
                end
            end
        end
    endgenerate

    // ---------------- rotate hue, split into sector and fraction
    logic [HB-1:0] hue_next;
    logic [HB+2:0] scaled_next;

    assign hue_next    = HB'(dv_quo_reg[QW]) + dv_shift_reg[QW];
    assign scaled_next = ((HB+3)'(hue_next) << 2) + ((HB+3)'(hue_next) << 1);

    logic          sh_vld_reg;
    logic [CB-1:0] sh_r_reg, sh_g_reg, sh_b_reg, sh_mx_reg, sh_mn_reg, sh_d_reg;
    logic [2:0]    sh_sector_reg;
    logic [HB-1:0] sh_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sh_vld_reg <= 1'b0;
        else if (en)
            sh_vld_reg <= dv_vld_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_r_reg      <= dv_r_reg[QW];
            sh_g_reg      <= dv_g_reg[QW];
            sh_b_reg      <= dv_b_reg[QW];
            sh_mx_reg     <= dv_mx_reg[QW];
            sh_mn_reg     <= dv_mn_reg[QW];
            sh_d_reg      <= dv_d_reg[QW];
            sh_sector_reg <= scaled_next[HB+2:HB];
            sh_frac_reg   <= scaled_next[HB-1:0];
        end
    end

    // ---------------- delta products for q and t
    localparam logic [HB:0] HUE_ONE = (HB+1)'(1) << HB;

    logic [PW-1:0] prod_q_next, prod_t_next;
    assign prod_q_next = PW'(sh_d_reg) * PW'(sh_frac_reg);
    assign prod_t_next = PW'(sh_d_reg) * PW'(HUE_ONE - (HB+1)'(sh_frac_reg));

    logic          sm_vld_reg;
    logic [CB-1:0] sm_r_reg, sm_g_reg, sm_b_reg, sm_mx_reg, sm_mn_reg, sm_d_reg;
    logic [2:0]    sm_sector_reg;
    logic [PW-1:0] sm_prod_q_reg, sm_prod_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_vld_reg <= 1'b0;
        else if (en)
            sm_vld_reg <= sh_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_r_reg      <= sh_r_reg;
            sm_g_reg      <= sh_g_reg;
            sm_b_reg      <= sh_b_reg;
            sm_mx_reg     <= sh_mx_reg;
            sm_mn_reg     <= sh_mn_reg;
            sm_d_reg      <= sh_d_reg;
            sm_sector_reg <= sh_sector_reg;
            sm_prod_q_reg <= prod_q_next;
            sm_prod_t_reg <= prod_t_next;
        end
    end

    // ---------------- round q and t, pick channels by sector
    localparam logic [PW-1:0] HALF = PW'(1) << (HB - 1);

    logic [PW-1:0] q_sum, t_sum;
    logic [CB-1:0] q_val, t_val, p_val, mx_val;
    logic [CB-1:0] ro_next, go_next, bo_next;
    pixel_out_t    result_next;

    always_comb
    begin
        q_sum  = sm_prod_q_reg + HALF;
        t_sum  = sm_prod_t_reg + HALF;
        q_val  = sm_mx_reg - CB'(q_sum >> HB);
        t_val  = sm_mx_reg - CB'(t_sum >> HB);
        p_val  = sm_mn_reg;
        mx_val = sm_mx_reg;
        unique case (sector_t'(sm_sector_reg))
            SECTOR_RED_UP:   begin ro_next = mx_val; go_next = t_val;  bo_next = p_val;  end
            SECTOR_GRN_DOWN: begin ro_next = q_val;  go_next = mx_val; bo_next = p_val;  end
            SECTOR_GRN_UP:   begin ro_next = p_val;  go_next = mx_val; bo_next = t_val;  end
            SECTOR_BLU_DOWN: begin ro_next = p_val;  go_next = q_val;  bo_next = mx_val; end
            SECTOR_BLU_UP:   begin ro_next = t_val;  go_next = p_val;  bo_next = mx_val; end
            default:         begin ro_next = mx_val; go_next = p_val;  bo_next = q_val;  end
        endcase
        // gray pixels pass straight through
        if (sm_d_reg == '0)
        begin
            ro_next = sm_r_reg;
            go_next = sm_g_reg;
            bo_next = sm_b_reg;
        end
        result_next.red_out   = PORT_CH_BITS'(ro_next);
        result_next.green_out = PORT_CH_BITS'(go_next);
        result_next.blue_out  = PORT_CH_BITS'(bo_next);
    end

    logic       out_vld_reg;
    pixel_out_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= sm_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= result_next;
    end

    assign en           = !out_vld_reg || result_ready;
    assign pixel_ready  = en;
    assign result_valid = out_vld_reg;
    assign result       = out_data_reg;

endmodule

// ----- hdl/rhr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_checker
// Port-level checks on the hue rotation unit, bound to the top level.
// ----------------------------------------------------------------------------
module rhr_checker
    import rhr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_ready,
    input pixel_in_t  pixel,
    input logic       result_valid,
    input logic       result_ready,
    input pixel_out_t result
);

    // a stalled item holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result item changed while stalled");

    // a stalled output freezes the whole pipeline
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !pixel_ready)
        else $error("input taken during output stall");

    // an empty output stage never refuses an item
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> pixel_ready)
        else $error("input refused with output stage empty");

    // the pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid on leaving reset");

endmodule

bind rgb_hue_rotation_unit rhr_checker u_rhr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and corner pixels through the hue rotation unit and compares
// each rotated pixel with an integer hsv prediction held in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    import rhr_pkg::*;

    localparam int HB = HUE_BITS_DEF;

    class hue_scoreboard;
        pixel_out_t pending[$];
        int errors;

        function automatic pixel_out_t rotate(pixel_in_t px);
            logic [63:0] r, g, b, mx, mn, d, num, h, sc, f, q, t;
            pixel_out_t o;
            logic [2:0] sec;
            r = px.red_in;
            g = px.green_in;
            b = px.blue_in;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            if (d == 0)
            begin
                o.red_out = r[7:0];
                o.green_out = g[7:0];
                o.blue_out = b[7:0];
                return o;
            end
            // a full turn is added first so the numerator never goes negative
            if (mx == r) num = 6 * d + g - b;
            else if (mx == g) num = 8 * d + b - r;
            else num = 10 * d + r - g;
            h = (((2 * num) << HB) + 6 * d) / (12 * d);
            h = (h + (64'(px.hue_shift) << (HB - SHIFT_BITS))) & ((64'd1 << HB) - 1);
            sc = h * 6;
            sec = 3'(sc >> HB);
            f = sc & ((64'd1 << HB) - 1);
            q = mx - ((d * f + (64'd1 << (HB - 1))) >> HB);
            t = mx - ((d * ((64'd1 << HB) - f) + (64'd1 << (HB - 1))) >> HB);
            case (sector_t'(sec))
                SECTOR_RED_UP:   o = '{mx[7:0], t[7:0], mn[7:0]};
                SECTOR_GRN_DOWN: o = '{q[7:0], mx[7:0], mn[7:0]};
                SECTOR_GRN_UP:   o = '{mn[7:0], mx[7:0], t[7:0]};
                SECTOR_BLU_DOWN: o = '{mn[7:0], q[7:0], mx[7:0]};
                SECTOR_BLU_UP:   o = '{t[7:0], mn[7:0], mx[7:0]};
                default:         o = '{mx[7:0], mn[7:0], q[7:0]};
            endcase
            return o;
        endfunction

        function void note_pixel(pixel_in_t px);
            pending = {pending, rotate(px)};
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(pixel_out_t res);
            pixel_out_t want;
            if (pending.size() == 0)
            begin
                report("unexpected item", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (res.red_out !== want.red_out) report("red", res.red_out, want.red_out);
            if (res.green_out !== want.green_out)
                report("green", res.green_out, want.green_out);
            if (res.blue_out !== want.blue_out) report("blue", res.blue_out, want.blue_out);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic pixel_valid = 0;
    logic pixel_ready;
    pixel_in_t pixel = '0;
    logic result_valid;
    logic result_ready = 0;
    pixel_out_t result;
    bit sending_done = 0;
    int ready_hold = 0;
    hue_scoreboard board = new();

    always #1 clk = ~clk;

    rgb_hue_rotation_unit dut (.*);

    // valid stays up across back-to-back items and drops only for an idle gap
    task send_pixel(pixel_in_t px);
        int idle;
        idle = $urandom_range(0, 3);
        if (idle != 0)
        begin
            pixel_valid <= 0;
            repeat (idle) @(posedge clk);
        end
        pixel_valid <= 1;
        pixel <= px;
        do @(posedge clk); while (!pixel_ready);
        board.note_pixel(px);
    endtask

    task send_random(int n);
        pixel_in_t px;
        for (int i = 0; i < n; i++)
        begin
            px = $bits(pixel_in_t)'({$urandom, $urandom});
            // some near-gray and saturated pixels
            if ($urandom_range(0, 7) == 0) px.green_in = 8'(px.red_in + $urandom_range(0, 2));
            if ($urandom_range(0, 7) == 0) px.blue_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
            send_pixel(px);
        end
    endtask

    // result side drops ready after taking each item, for a random hold that may be zero
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            board.check_result(result);
            ready_hold = $urandom_range(0, 3);
        end
        if (ready_hold != 0)
        begin
            result_ready <= 1'b0;
            ready_hold--;
        end
        else
            result_ready <= 1'b1;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // extremes, gray, ties for the maximum, each sector, wrap of the shift
        send_pixel('{8'h00, 8'h00, 8'h00, 16'h0000});
        send_pixel('{8'hff, 8'hff, 8'hff, 16'hffff});
        send_pixel('{8'h80, 8'h80, 8'h80, 16'h1234});
        send_pixel('{8'hff, 8'h00, 8'h00, 16'h0000});
        send_pixel('{8'h00, 8'hff, 8'h00, 16'h0000});
        send_pixel('{8'h00, 8'h00, 8'hff, 16'h0000});
        send_pixel('{8'hff, 8'hff, 8'h00, 16'h8000});
        send_pixel('{8'h00, 8'hff, 8'hff, 16'h5555});
        send_pixel('{8'hff, 8'h00, 8'hff, 16'haaaa});
        send_pixel('{8'hff, 8'h00, 8'h00, 16'hffff});
        send_pixel('{8'h01, 8'h00, 8'h00, 16'h2aab});
        send_pixel('{8'hff, 8'hfe, 8'h00, 16'h0001});
        send_pixel('{8'h55, 8'haa, 8'h0f, 16'hd555});
        for (int s = 0; s < 6; s++) send_pixel('{8'hc8, 8'h32, 8'h64, 16'(s * 10923)});
        // hold off until the pipeline has drained
        pixel_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        send_random(850);
        pixel_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        send_random(850);
        pixel_valid <= 0;
        sending_done = 1;
    end

    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
